FILE: src/aesmp_pkg.sv
// Shared constants, types and functions for the AES-128 Miyaguchi-Preneel expander.
package aesmp_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int COUNT_W = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] CSR_IV_WORD0 = 2'd0;
   localparam logic [1:0] CSR_IV_WORD1 = 2'd1;
   localparam logic [1:0] CSR_IV_WORD2 = 2'd2;
   localparam logic [1:0] CSR_IV_WORD3 = 2'd3;

   localparam logic [7:0] RCON_FIRST = 8'h01;

   typedef logic [127:0] block_type;

   typedef struct packed {
      logic start;
      logic done;
   } core_ctl_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[x];
   endfunction

endpackage

FILE: src/aesmp_round_core.sv
// Byte-serial AES-128 core: one S-box per cycle, key expanded on the fly.
module aesmp_round_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  aesmp_pkg::block_type    key,
   input  aesmp_pkg::block_type    text,
   output logic                    done,
   output aesmp_pkg::block_type    result
);
   import aesmp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUB  = 2'd1;
   localparam logic [1:0] ST_KEY  = 2'd2;
   localparam logic [1:0] ST_MIX  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  round_ff, round_in;
   logic [3:0]  byte_ff, byte_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic [127:0] s_ff, s_in;
   logic [127:0] rk_ff, rk_in;
   logic [31:0]  t_ff, t_in;
   logic         done_ff, done_in;

   logic [127:0] sr;
   logic [127:0] mc;
   logic [127:0] nk;
   logic [7:0]   sb;

   assign sb = sbox(s_ff[127:120]);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sr[127 - 8*(i + 4*c) -: 8] = s_ff[127 - 8*(i + 4*((c + i) & 3)) -: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3, al;
         a0 = sr[127 - 32*c -: 8];
         a1 = sr[119 - 32*c -: 8];
         a2 = sr[111 - 32*c -: 8];
         a3 = sr[103 - 32*c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mc[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         mc[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         mc[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         mc[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      nk[127:96] = rk_ff[127:96] ^ t_ff ^ {rcon_ff, 24'h0};
      nk[95:64]  = rk_ff[95:64] ^ nk[127:96];
      nk[63:32]  = rk_ff[63:32] ^ nk[95:64];
      nk[31:0]   = rk_ff[31:0] ^ nk[63:32];
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      byte_in  = byte_ff;
      rcon_in  = rcon_ff;
      s_in     = s_ff;
      rk_in    = rk_ff;
      t_in     = t_ff;
      done_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               s_in     = text ^ key;
               rk_in    = key;
               rcon_in  = RCON_FIRST;
               round_in = 4'd1;
               byte_in  = 4'd0;
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            s_in    = {s_ff[119:0], sb};
            byte_in = byte_ff + 4'd1;
            if (byte_ff == 4'd15) begin
               byte_in  = 4'd0;
               state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            t_in    = {t_ff[23:0], sbox(rk_ff[8*(3 - (32'(byte_ff[1:0]) + 1) % 4) +: 8])};
            byte_in = byte_ff + 4'd1;
            if (byte_ff == 4'd3) begin
               byte_in  = 4'd0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            s_in     = ((round_ff == 4'd10) ? sr : mc) ^ nk;
            rk_in    = nk;
            rcon_in  = xtime(rcon_ff);
            round_in = round_ff + 4'd1;
            if (round_ff == 4'd10) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SUB;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         round_ff <= '0;
         byte_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         round_ff <= round_in;
         byte_ff  <= byte_in;
      end
      rcon_ff <= rcon_in;
      s_ff    <= s_in;
      rk_ff   <= rk_in;
      t_ff    <= t_in;
   end

   assign done   = done_ff;
   assign result = s_ff;
endmodule

FILE: src/aesmp_chain_ctrl.sv
// Block chaining control: holds seed and chain key and sequences the run.
module aesmp_chain_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [63:0]                   req_seed_hi,
   input  logic [63:0]                   req_seed_lo,
   input  logic [aesmp_pkg::COUNT_W-1:0] req_block_count,
   input  aesmp_pkg::block_type          iv,
   output aesmp_pkg::core_ctl_type       ctl_out,
   input  logic                          core_done,
   input  aesmp_pkg::block_type          core_result,
   output aesmp_pkg::block_type          core_key,
   output aesmp_pkg::block_type          core_text,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [63:0]                   rsp_block_hi,
   output logic [63:0]                   rsp_block_lo,
   output logic                          rsp_last_block
);
   import aesmp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   block_type          seed_ff, seed_in;
   block_type          key_ff, key_in;
   logic               ov_ff, ov_in;
   block_type          ob_ff, ob_in;
   logic               ol_ff, ol_in;
   logic               start;
   logic [COUNT_W-1:0] n;
   block_type          blk;

   always_comb begin
      n = req_block_count;
      if (n == '0) n = COUNT_W'(1);
      if (n > COUNT_W'(MAX_BLOCKS)) n = COUNT_W'(MAX_BLOCKS);
   end

   assign blk = core_result ^ key_ff ^ seed_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      seed_in  = seed_ff;
      key_in   = key_ff;
      ov_in    = ov_ff;
      ob_in    = ob_ff;
      ol_in    = ol_ff;
      start    = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               seed_in  = {req_seed_hi, req_seed_lo};
               key_in   = iv;
               left_in  = n;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!ov_in) begin
               start    = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (core_done) begin
               ov_in   = 1'b1;
               ob_in   = blk;
               ol_in   = (left_ff == COUNT_W'(1));
               key_in  = blk;
               left_in = left_ff - COUNT_W'(1);
               state_in = (left_ff == COUNT_W'(1)) ? ST_IDLE : ST_WAIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         left_ff  <= left_in;
      end
      seed_ff <= seed_in;
      key_ff  <= key_in;
      ob_ff   <= ob_in;
      ol_ff   <= ol_in;
   end

   assign ctl_out.start  = start;
   assign ctl_out.done   = core_done;
   assign core_key       = key_ff;
   assign core_text      = seed_ff;
   assign rsp_valid      = ov_ff;
   assign rsp_block_hi   = ob_ff[127:64];
   assign rsp_block_lo   = ob_ff[63:0];
   assign rsp_last_block = ol_ff;
endmodule

FILE: src/aes128_mp_prg_expander_unit.sv
// Top level of the AES-128 Miyaguchi-Preneel seed expander.
// Each block is a start from the chain control, ten rounds in the byte-serial AES core
// with one S-box for the state bytes and one for the key schedule, and a block capture.
// Within a run, the next block starts only once the previous block is taken; the next
// seed is taken once the last block is presented.
// Synchronous active-high reset returns the IV registers to their defaults and idles the unit.
module aes128_mp_prg_expander_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [63:0]                           req_seed_hi,
   input  logic [63:0]                           req_seed_lo,
   input  logic [aesmp_pkg::COUNT_W-1:0]         req_block_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [63:0]                           rsp_block_hi,
   output logic [63:0]                           rsp_block_lo,
   output logic                                  rsp_last_block,
   input  logic                                  csr_write,
   input  logic [aesmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                           csr_data
);
   import aesmp_pkg::*;

   logic [31:0]   iv0_ff, iv1_ff, iv2_ff, iv3_ff;
   core_ctl_type  ctl;
   logic          core_done;
   block_type     core_result, core_key, core_text;

   always_ff @(posedge clock) begin
      if (reset) begin
         iv0_ff <= 32'h2b7e1516;
         iv1_ff <= 32'h28aed2a6;
         iv2_ff <= 32'habf71588;
         iv3_ff <= 32'h09cf4f3c;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IV_WORD0: iv0_ff <= csr_data;
            CSR_IV_WORD1: iv1_ff <= csr_data;
            CSR_IV_WORD2: iv2_ff <= csr_data;
            CSR_IV_WORD3: iv3_ff <= csr_data;
            default: iv0_ff <= iv0_ff;
         endcase
      end
   end

   aesmp_chain_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_seed_hi     (req_seed_hi),
      .req_seed_lo     (req_seed_lo),
      .req_block_count (req_block_count),
      .iv              ({iv0_ff, iv1_ff, iv2_ff, iv3_ff}),
      .ctl_out         (ctl),
      .core_done       (core_done),
      .core_result     (core_result),
      .core_key        (core_key),
      .core_text       (core_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_block_hi    (rsp_block_hi),
      .rsp_block_lo    (rsp_block_lo),
      .rsp_last_block  (rsp_last_block)
   );

   aesmp_round_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.start),
      .key    (core_key),
      .text   (core_text),
      .done   (core_done),
      .result (core_result)
   );
endmodule

FILE: verif/aes128_mp_prg_expander_unit_tb.sv
// Self-checking testbench for the AES-128 Miyaguchi-Preneel seed expander.
module aes128_mp_prg_expander_unit_tb;
   import aesmp_pkg::*;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
      logic        last;
   } chain_block_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [63:0]          req_seed_hi = '0;
   logic [63:0]          req_seed_lo = '0;
   logic [COUNT_W-1:0]   req_block_count = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [63:0]          rsp_block_hi;
   logic [63:0]          rsp_block_lo;
   logic                 rsp_last_block;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IV_WORD0;
   logic [31:0]          csr_data = '0;

   logic [7:0]   sub_byte [256];
   logic [31:0]  iv_key [4];
   chain_block_type pending_blocks [$];
   int           error_count = 0;
   int           quiet_cycles = 0;
   int           rsp_gap = 0;
   int           rsp_hold = 0;
   int           hold_request = 0;
   bit           no_idle = 1'b0;

   localparam int QUIET_LIMIT = 60000;

   aes128_mp_prg_expander_unit dut (.*);

   always #2 clock = ~clock;

   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = gf_dbl(a);
         b = b >> 1;
      end
      return p;
   endfunction

   task automatic build_sub_bytes();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
         if (x == 0) inv = 8'h00;
         sub_byte[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                       {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   endtask

   function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                   input logic [127:0] text);
      logic [7:0] rk [16];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] rcon;
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] res;
      rcon = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         s[i] = text[127-8*i -: 8] ^ rk[i];
      end
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) s[i] = sub_byte[s[i]];
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) t[i+4*c] = s[i+4*((c+i)%4)];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (r < 10) begin
               all = a0 ^ a1 ^ a2 ^ a3;
               s[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
               s[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
               s[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
               s[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
            end else begin
               s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
            end
         end
         w[0] = sub_byte[rk[13]] ^ rcon;
         w[1] = sub_byte[rk[14]];
         w[2] = sub_byte[rk[15]];
         w[3] = sub_byte[rk[12]];
         for (int i = 0; i < 4; i++) rk[i] ^= w[i];
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
         rcon = gf_dbl(rcon);
         for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
   endfunction

   task automatic predict_chain(input logic [63:0] hi, input logic [63:0] lo,
                                input logic [COUNT_W-1:0] count);
      int           n;
      logic [127:0] key;
      logic [127:0] seed;
      chain_block_type b;
      n = count;
      if (n < 1) n = 1;
      if (n > MAX_BLOCKS) n = MAX_BLOCKS;
      seed = {hi, lo};
      key = {iv_key[0], iv_key[1], iv_key[2], iv_key[3]};
      for (int k = 0; k < n; k++) begin
         key = aes128_encrypt(key, seed) ^ key ^ seed;
         b.hi = key[127:64];
         b.lo = key[63:0];
         b.last = (k == n - 1);
         pending_blocks.push_back(b);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 250);
   endfunction

   always @(posedge clock) begin
      chain_block_type b;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected block hi=%h lo=%h last=%b", $time,
                     rsp_block_hi, rsp_block_lo, rsp_last_block);
            error_count++;
         end else begin
            b = pending_blocks.pop_front();
            if (rsp_block_hi !== b.hi) begin
               $display("%0t: block_hi expected %h actual %h", $time, b.hi, rsp_block_hi);
               error_count++;
            end
            if (rsp_block_lo !== b.lo) begin
               $display("%0t: block_lo expected %h actual %h", $time, b.lo, rsp_block_lo);
               error_count++;
            end
            if (rsp_last_block !== b.last) begin
               $display("%0t: last_block expected %b actual %b", $time, b.last,
                        rsp_last_block);
               error_count++;
            end
         end
      end
      if (hold_request != 0) begin
         rsp_hold = hold_request;
         hold_request = 0;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0 && !no_idle) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_seed(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [COUNT_W-1:0] count);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_seed_hi <= hi;
      req_seed_lo <= lo;
      req_block_count <= count;
      do @(posedge clock); while (!req_ready);
      predict_chain(hi, lo, count);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (240) @(posedge clock);
   endtask

   task automatic write_iv(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      iv_key[idx] = value;
   endtask

   task automatic write_all_iv(input logic [127:0] key);
      wait_drain();
      write_iv(CSR_IV_WORD0, key[127:96]);
      write_iv(CSR_IV_WORD1, key[95:64]);
      write_iv(CSR_IV_WORD2, key[63:32]);
      write_iv(CSR_IV_WORD3, key[31:0]);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [6:0] random_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 92) return 7'($urandom_range(0, 3));
      if (r < 97) return 7'($urandom_range(4, 16));
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic test_directed();
      send_seed(64'h3243f6a8885a308d, 64'h313198a2e0370734, 7'd1);
      send_seed(64'h0, 64'h0, 7'd0);
      send_seed({64{1'b1}}, {64{1'b1}}, 7'd2);
      send_seed(64'h0123456789abcdef, 64'hfedcba9876543210, 7'd3);
      send_seed(64'h8000000000000000, 64'h0000000000000001, 7'd64);
      send_seed(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 7'd65);
      send_seed(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 7'd127);
      send_seed({$urandom, $urandom}, {$urandom, $urandom}, 7'd1);
   endtask

   task automatic test_iv_extremes();
      write_all_iv('0);
      send_seed(64'h0, 64'h0, 7'd2);
      send_seed({$urandom, $urandom}, {$urandom, $urandom}, 7'd1);
      write_all_iv({128{1'b1}});
      send_seed({64{1'b1}}, 64'h0, 7'd2);
      send_seed({$urandom, $urandom}, {$urandom, $urandom}, 7'd0);
   endtask

   task automatic test_backpressure();
      wait_drain();
      hold_request = 3000;
      no_idle = 1'b1;
      for (int i = 0; i < 6; i++)
         send_seed({$urandom, $urandom}, {$urandom, $urandom}, 7'd2);
      no_idle = 1'b0;
      wait_drain();
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 5; phase++) begin
         write_all_iv({$urandom, $urandom, $urandom, $urandom});
         no_idle = (phase == 2);
         for (int i = 0; i < 80; i++)
            send_seed({$urandom, $urandom}, {$urandom, $urandom}, random_count());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      iv_key[0] = 32'h2b7e1516;
      iv_key[1] = 32'h28aed2a6;
      iv_key[2] = 32'habf71588;
      iv_key[3] = 32'h09cf4f3c;
      build_sub_bytes();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_iv_extremes();
      test_backpressure();
      test_random();
      wait_drain();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: aes128_mp_prg_expander_unit.f
src/aesmp_pkg.sv
src/aesmp_round_core.sv
src/aesmp_chain_ctrl.sv
src/aes128_mp_prg_expander_unit.sv
verif/aes128_mp_prg_expander_unit_tb.sv
